### hw/rtl/spuoc_pkg.sv
package spuoc_pkg;

    // Image and sprite geometry
    localparam int BASE_WIDTH      = 256;
    localparam int BASE_HEIGHT     = 256;
    localparam int ENLARGE         = 6;
    localparam int SPRITE_MAX_COLS = 32;
    localparam int SPRITE_MAX_ROWS = 32;
    localparam int NUDGE_UP        = 20;
    localparam int OUTLINE_LEVEL   = 57;

    localparam int STORE_DEPTH = SPRITE_MAX_COLS * SPRITE_MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int COL_W = $clog2(BASE_WIDTH);
    localparam int ROW_W = $clog2(BASE_HEIGHT);

    // effective sprite size 1..max, and sprite coordinates 0..max-1
    localparam int SC_W = $clog2(SPRITE_MAX_COLS + 1);
    localparam int SR_W = $clog2(SPRITE_MAX_ROWS + 1);
    localparam int SX_W = (SPRITE_MAX_COLS > 1) ? $clog2(SPRITE_MAX_COLS) : 1;
    localparam int SY_W = (SPRITE_MAX_ROWS > 1) ? $clog2(SPRITE_MAX_ROWS) : 1;
    localparam int IDX_W = SY_W + SC_W + 1;

    // window coordinates inside the enlarged sprite
    localparam int WIN_MAX = ((SPRITE_MAX_COLS > SPRITE_MAX_ROWS) ?
                              SPRITE_MAX_COLS : SPRITE_MAX_ROWS) * ENLARGE;
    localparam int WX_W    = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
    localparam int POS_MAX_W = (COL_W > ROW_W) ?
                               ((COL_W > WX_W) ? COL_W : WX_W) :
                               ((ROW_W > WX_W) ? ROW_W : WX_W);
    localparam int POS_W   = POS_MAX_W + 2;

    // divide by ENLARGE: multiply by rounded-up reciprocal, exact below 2**WX_W
    localparam int DIV_SH  = WX_W + $clog2(ENLARGE);
    localparam int DIV_MUL = ((2 ** DIV_SH) + ENLARGE - 1) / ENLARGE;
    localparam int DIV_MW  = DIV_SH + 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int PWR_W      = 8;
    localparam int TINT_W     = 9;
    localparam int SIZE_W     = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POWER_LEVEL = 3'd0,
        REG_TINT_RED    = 3'd1,
        REG_TINT_GREEN  = 3'd2,
        REG_TINT_BLUE   = 3'd3,
        REG_SPRITE_COLS = 3'd4,
        REG_SPRITE_ROWS = 3'd5
    } t_cfg_reg;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_BASE = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // packs as alpha:blue:green:red, the layout of a sprite store word
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgba;

    localparam int LEVELS      = 5;
    localparam int LVL_SEL_W   = 3;

    function automatic t_rgb level_colour(input logic [LVL_SEL_W-1:0] sel);
        t_rgb c;
        unique case (sel)
            3'd0:    c = '{red: 8'd51,  green: 8'd115, blue: 8'd26};
            3'd1:    c = '{red: 8'd154, green: 8'd154, blue: 8'd51};
            3'd2:    c = '{red: 8'd77,  green: 8'd102, blue: 8'd230};
            3'd3:    c = '{red: 8'd205, green: 8'd26,  blue: 8'd243};
            default: c = '{red: 8'd179, green: 8'd26,  blue: 8'd38};
        endcase
        return c;
    endfunction

    // (span)/2 truncated toward zero
    function automatic logic signed [POS_W-1:0] centre_offset(
        input logic signed [POS_W+1:0] span);
        logic signed [POS_W+1:0] mag;
        logic signed [POS_W+1:0] half;
        mag  = span[POS_W+1] ? -span : span;
        half = mag >>> 1;
        if (span[POS_W+1]) begin
            half = -half;
        end
        return half[POS_W-1:0];
    endfunction

    // the eight neighbours of a sprite pixel
    localparam int NB_COUNT = 8;
    localparam int NB_DX [NB_COUNT] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    localparam int NB_DY [NB_COUNT] = '{-1, -1, -1, 0, 0, 1, 1, 1};

endpackage

### hw/rtl/spuoc_ram.sv
module spuoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/sprite_upscale_outline_compositor.sv
// Sprite upscale and outline compositor.
// Three valid/ready channels: a configuration write channel (index, data), an
// input channel and a result channel. An input word with action 0 stores the
// next sprite pixel in raster order and gives no result; action 1 presents the
// next base-image pixel and gives exactly one composited result word.
// Configuration is taken only while no input word is in the pipeline or on offer.
// Throughput is one input word per clock, loads and base pixels alike, while
// the result channel is not stalled. A result word passes through the input
// register, the window-test register, the address stage with the sprite
// memory read, and the result register. The sprite sits in one 32-bit memory
// for the centre pixel and eight 1-bit opacity copies, one per neighbour, so
// every base pixel reads all nine in the same cycle.
// Reset (synchronous, active low) clears the pipeline, the load position, the
// raster counters and the registers to their defaults; sprite memory keeps
// whatever it held and must be loaded before it is shown.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and input ready drops in the same cycle; nothing is lost.
module sprite_upscale_outline_compositor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [spuoc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spuoc_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic [7:0]                       i_pix_red,
    input  logic [7:0]                       i_pix_green,
    input  logic [7:0]                       i_pix_blue,
    input  logic [7:0]                       i_pix_alpha,

    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_out_red,
    output logic [7:0]                       o_out_green,
    output logic [7:0]                       o_out_blue,
    output logic [7:0]                       o_out_alpha,
    output logic                             o_frame_end
);

    import spuoc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [PWR_W-1:0]  r_power_level;
    logic [TINT_W-1:0] r_tint_red;
    logic [TINT_W-1:0] r_tint_green;
    logic [TINT_W-1:0] r_tint_blue;
    logic [SIZE_W-1:0] r_sprite_cols;
    logic [SIZE_W-1:0] r_sprite_rows;

    logic en;
    logic r_s0_v, r_s1_v, r_s2_v;
    logic r_out_valid;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    // a word offered alongside a write would see the old window offsets
    assign o_cfg_ready = !(r_s0_v || r_s1_v || r_s2_v || i_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_level <= PWR_W'(1);
            r_tint_red    <= TINT_W'(256);
            r_tint_green  <= TINT_W'(256);
            r_tint_blue   <= TINT_W'(256);
            r_sprite_cols <= SIZE_W'(32);
            r_sprite_rows <= SIZE_W'(32);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_POWER_LEVEL: r_power_level <= i_cfg_data[PWR_W-1:0];
                REG_TINT_RED:    r_tint_red    <= i_cfg_data[TINT_W-1:0];
                REG_TINT_GREEN:  r_tint_green  <= i_cfg_data[TINT_W-1:0];
                REG_TINT_BLUE:   r_tint_blue   <= i_cfg_data[TINT_W-1:0];
                REG_SPRITE_COLS: r_sprite_cols <= i_cfg_data[SIZE_W-1:0];
                REG_SPRITE_ROWS: r_sprite_rows <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- values derived from configuration ----------------
    // Registered every cycle; a written value reaches these registers before any word uses it.
    logic [SC_W-1:0]          n_cols_eff, r_cols_eff;
    logic [SR_W-1:0]          n_rows_eff, r_rows_eff;
    logic [CNT_W-1:0]         n_count, r_count;
    logic [POS_W-1:0]         n_win_w, r_win_w;
    logic [POS_W-1:0]         n_win_h, r_win_h;
    logic signed [POS_W+1:0]  n_span_x, n_span_y;
    logic signed [POS_W-1:0]  n_offx, r_offx;
    logic signed [POS_W-1:0]  n_offy, r_offy;
    logic [LVL_SEL_W-1:0]     n_lvl_sel;
    t_rgb                     n_lvl, r_lvl;
    t_rgb                     n_outline, r_outline;
    logic [15:0]              ol_red, ol_green, ol_blue;

    always_comb begin
        if (r_sprite_cols == '0) begin
            n_cols_eff = SC_W'(1);
        end else if (r_sprite_cols > SPRITE_MAX_COLS) begin
            n_cols_eff = SC_W'(SPRITE_MAX_COLS);
        end else begin
            n_cols_eff = SC_W'(r_sprite_cols);
        end
        if (r_sprite_rows == '0) begin
            n_rows_eff = SR_W'(1);
        end else if (r_sprite_rows > SPRITE_MAX_ROWS) begin
            n_rows_eff = SR_W'(SPRITE_MAX_ROWS);
        end else begin
            n_rows_eff = SR_W'(r_sprite_rows);
        end
        n_count  = CNT_W'(n_cols_eff) * CNT_W'(n_rows_eff);
        n_win_w  = POS_W'(n_cols_eff * ENLARGE);
        n_win_h  = POS_W'(n_rows_eff * ENLARGE);
        n_span_x = $signed((POS_W+2)'(BASE_WIDTH)) - $signed({2'b00, n_win_w});
        n_span_y = $signed((POS_W+2)'(BASE_HEIGHT - NUDGE_UP)) - $signed({2'b00, n_win_h});
        n_offx   = centre_offset(n_span_x);
        n_offy   = centre_offset(n_span_y);

        if (r_power_level <= PWR_W'(1)) begin
            n_lvl_sel = '0;
        end else if (r_power_level >= PWR_W'(LEVELS)) begin
            n_lvl_sel = LVL_SEL_W'(LEVELS - 1);
        end else begin
            n_lvl_sel = LVL_SEL_W'(r_power_level - PWR_W'(1));
        end
        n_lvl     = level_colour(n_lvl_sel);
        ol_red    = 16'(OUTLINE_LEVEL) * 16'(n_lvl.red);
        ol_green  = 16'(OUTLINE_LEVEL) * 16'(n_lvl.green);
        ol_blue   = 16'(OUTLINE_LEVEL) * 16'(n_lvl.blue);
        n_outline = '{red: ol_red[15:8], green: ol_green[15:8], blue: ol_blue[15:8]};
    end

    always_ff @(posedge i_clk) begin
        r_cols_eff <= n_cols_eff;
        r_rows_eff <= n_rows_eff;
        r_count    <= n_count;
        r_win_w    <= n_win_w;
        r_win_h    <= n_win_h;
        r_offx     <= n_offx;
        r_offy     <= n_offy;
        r_lvl      <= n_lvl;
        r_outline  <= n_outline;
    end

    // ---------------- accept: raster counters, input register ----------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             col_wrap, row_wrap;

    logic             r_s0_action;
    t_rgba            r_s0_pix;
    logic [COL_W-1:0] r_s0_col;
    logic [ROW_W-1:0] r_s0_row;
    logic             r_s0_last;

    assign col_wrap = (r_col == COL_W'(BASE_WIDTH - 1));
    assign row_wrap = (r_row == ROW_W'(BASE_HEIGHT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (en && i_in_valid && (i_action == ACTION_BASE)) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_action <= i_action;
            r_s0_pix    <= '{alpha: i_pix_alpha, blue: i_pix_blue,
                             green: i_pix_green, red: i_pix_red};
            r_s0_col    <= r_col;
            r_s0_row    <= r_row;
            r_s0_last   <= col_wrap && row_wrap;
        end
    end

    // ---------------- stage 0: window test and sprite coordinates ----------------
    logic signed [POS_W-1:0]  wx, wy;
    logic                     n_in_win;
    logic [WX_W+DIV_MW-1:0]   sx_prod, sy_prod;
    logic [SX_W-1:0]          n_sx;
    logic [SY_W-1:0]          n_sy;

    always_comb begin
        wx = $signed(POS_W'(r_s0_col)) - r_offx;
        wy = $signed(POS_W'(r_s0_row)) - r_offy;
        n_in_win = !wx[POS_W-1] && !wy[POS_W-1] &&
                   ($unsigned(wx) < r_win_w) && ($unsigned(wy) < r_win_h);
        sx_prod = (WX_W+DIV_MW)'(wx[WX_W-1:0]) * (WX_W+DIV_MW)'(DIV_MUL);
        sy_prod = (WX_W+DIV_MW)'(wy[WX_W-1:0]) * (WX_W+DIV_MW)'(DIV_MUL);
        n_sx = sx_prod[DIV_SH +: SX_W];
        n_sy = sy_prod[DIV_SH +: SY_W];
    end

    logic            r_s1_action;
    t_rgba           r_s1_pix;
    logic            r_s1_last;
    logic            r_s1_in_win;
    logic [SX_W-1:0] r_s1_sx;
    logic [SY_W-1:0] r_s1_sy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_action <= r_s0_action;
            r_s1_pix    <= r_s0_pix;
            r_s1_last   <= r_s0_last;
            r_s1_in_win <= n_in_win;
            r_s1_sx     <= n_sx;
            r_s1_sy     <= n_sy;
        end
    end

    // ---------------- stage 1: store addresses, loads, base colour ----------------
    logic [IDX_W-1:0]    ctr_idx, row_up, row_dn, row_sel;
    logic [IDX_W-1:0]    nb_addr [NB_COUNT];
    logic [NB_COUNT-1:0] n_nb_ok;
    logic                x_lo_ok, x_hi_ok, y_lo_ok, y_hi_ok;
    logic                x_ok, y_ok;

    always_comb begin
        ctr_idx = IDX_W'(r_s1_sy) * IDX_W'(r_cols_eff) + IDX_W'(r_s1_sx);
        row_up  = ctr_idx - IDX_W'(r_cols_eff);
        row_dn  = ctr_idx + IDX_W'(r_cols_eff);
        x_lo_ok = (r_s1_sx != '0);
        y_lo_ok = (r_s1_sy != '0);
        x_hi_ok = ((SC_W+1)'(r_s1_sx) + (SC_W+1)'(1)) < (SC_W+1)'(r_cols_eff);
        y_hi_ok = ((SR_W+1)'(r_s1_sy) + (SR_W+1)'(1)) < (SR_W+1)'(r_rows_eff);
        for (int k = 0; k < NB_COUNT; k++) begin
            if (NB_DY[k] < 0) begin
                row_sel = row_up;
                y_ok    = y_lo_ok;
            end else if (NB_DY[k] > 0) begin
                row_sel = row_dn;
                y_ok    = y_hi_ok;
            end else begin
                row_sel = ctr_idx;
                y_ok    = 1'b1;
            end
            if (NB_DX[k] < 0) begin
                nb_addr[k] = row_sel - IDX_W'(1);
                x_ok       = x_lo_ok;
            end else if (NB_DX[k] > 0) begin
                nb_addr[k] = row_sel + IDX_W'(1);
                x_ok       = x_hi_ok;
            end else begin
                nb_addr[k] = row_sel;
                x_ok       = 1'b1;
            end
            n_nb_ok[k] = x_ok && y_ok;
        end
    end

    // sprite load position; a position past the sprite size restarts at zero
    logic [ADDR_W-1:0] r_lp, load_pos;
    logic [CNT_W-1:0]  load_inc;
    logic              load_we;

    assign load_pos = (CNT_W'(r_lp) < r_count) ? r_lp : '0;
    assign load_inc = CNT_W'(load_pos) + CNT_W'(1);
    assign load_we  = en && r_s1_v && (r_s1_action == ACTION_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
        end else if (load_we) begin
            r_lp <= (load_inc == r_count) ? '0 : load_inc[ADDR_W-1:0];
        end
    end

    logic [15:0] base_red, base_green, base_blue;

    assign base_red   = 16'(r_s1_pix.red)   * 16'(r_lvl.red);
    assign base_green = 16'(r_s1_pix.green) * 16'(r_lvl.green);
    assign base_blue  = 16'(r_s1_pix.blue)  * 16'(r_lvl.blue);

    logic                r_s2_action;
    logic                r_s2_last;
    logic                r_s2_in_win;
    logic [NB_COUNT-1:0] r_s2_nb_ok;
    t_rgb                r_s2_base;
    logic [7:0]          r_s2_alpha;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_action <= r_s1_action;
            r_s2_last   <= r_s1_last;
            r_s2_in_win <= r_s1_in_win;
            r_s2_nb_ok  <= n_nb_ok;
            r_s2_base   <= '{red: base_red[15:8], green: base_green[15:8],
                             blue: base_blue[15:8]};
            r_s2_alpha  <= r_s1_pix.alpha;
        end
    end

    // ---------------- sprite store: centre word and opacity copies ----------------
    t_rgba               sp_word;
    logic [NB_COUNT-1:0] nb_opaque;

    spuoc_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_pos),
        .i_wdata (r_s1_pix),
        .i_re    (en),
        .i_raddr (ctr_idx[ADDR_W-1:0]),
        .o_rdata (sp_word)
    );

    for (genvar k = 0; k < NB_COUNT; k++) begin : g_nb
        spuoc_ram #(
            .WIDTH (1),
            .DEPTH (STORE_DEPTH)
        ) u_nb_ram (
            .i_clk   (i_clk),
            .i_we    (load_we),
            .i_waddr (load_pos),
            .i_wdata (r_s1_pix.alpha != 8'd0),
            .i_re    (en),
            .i_raddr (nb_addr[k][ADDR_W-1:0]),
            .o_rdata (nb_opaque[k])
        );
    end

    // ---------------- stage 2: tint, outline, select ----------------
    logic [16:0] tint_red, tint_green, tint_blue;
    logic        outline;
    t_rgb        n_res_rgb;
    logic [7:0]  n_res_alpha;

    always_comb begin
        tint_red   = 17'(sp_word.red)   * 17'(r_tint_red);
        tint_green = 17'(sp_word.green) * 17'(r_tint_green);
        tint_blue  = 17'(sp_word.blue)  * 17'(r_tint_blue);
        outline    = |(nb_opaque & r_s2_nb_ok);

        n_res_rgb   = r_s2_base;
        n_res_alpha = r_s2_alpha;
        if (r_s2_in_win) begin
            if (sp_word.alpha != 8'd0) begin
                // Q1.8 tint, saturated to a byte
                n_res_rgb.red   = tint_red[16]   ? 8'hFF : tint_red[15:8];
                n_res_rgb.green = tint_green[16] ? 8'hFF : tint_green[15:8];
                n_res_rgb.blue  = tint_blue[16]  ? 8'hFF : tint_blue[15:8];
                n_res_alpha     = sp_word.alpha;
            end else if (outline) begin
                n_res_rgb   = r_outline;
                n_res_alpha = 8'hFF;
            end
        end
    end

    // ---------------- pipeline valids and result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v      <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s0_v      <= i_in_valid;
            r_s1_v      <= r_s0_v;
            r_s2_v      <= r_s1_v;
            r_out_valid <= r_s2_v && (r_s2_action == ACTION_BASE);
        end
    end

    t_rgb       r_res_rgb;
    logic [7:0] r_res_alpha;
    logic       r_res_last;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_rgb   <= n_res_rgb;
            r_res_alpha <= n_res_alpha;
            r_res_last  <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_res_rgb.red;
    assign o_out_green = r_res_rgb.green;
    assign o_out_blue  = r_res_rgb.blue;
    assign o_out_alpha = r_res_alpha;
    assign o_frame_end = r_res_last;

endmodule
